// ----- rtl/core/prblr_pkg.sv -----
package prblr_pkg;

    localparam int MAP_BITS  = 4096;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int NUM_W     = 14;
    localparam int POS_W     = NUM_W + 1;
    localparam int RECV_W    = 13;
    localparam int CNT_W     = 6;
    localparam int SID_W     = 8;

    localparam logic [NUM_W-1:0]  ALL_MORE  = 14'h3FFF;
    localparam logic [RECV_W-1:0] RECV_MAX  = 13'h1FFF;
    localparam logic [CNT_W-1:0]  ENTRY_CAP = 6'd32;
    localparam logic [CNT_W-1:0]  MAX_RESET = 6'd10;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] KIND_NEW  = 3'd0;
    localparam logic [2:0] KIND_DUP  = 3'd1;
    localparam logic [2:0] KIND_REJ  = 3'd2;
    localparam logic [2:0] KIND_MISS = 3'd3;
    localparam logic [2:0] KIND_SUM  = 3'd4;

    localparam logic [1:0] CMD_REJ  = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_QRY  = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [SID_W-1:0] session_tag;
        logic [NUM_W-1:0] packet_number;
        logic             last_packet_flag;
        logic             ack_request;
        logic [NUM_W-1:0] query_total;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [NUM_W-1:0]  missing_packet;
        logic [CNT_W-1:0]  loss_count;
        logic [RECV_W-1:0] received_count;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SID_W-1:0] sid;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] idx;
        logic             beyond;
        logic             lastf;
        logic             ack;
        logic [NUM_W-1:0] qtot;
    } t_cmd;

endpackage

// ----- rtl/core/packet_receipt_bitmap_loss_report_top.sv -----
// Receive bitmap with loss report for one numbered session at a time.
// Input channel (i_in_valid / o_in_stall / i_in_data): one request per data
// packet or sender query. Output channel (o_out_valid / i_out_stall /
// o_out_data): one or more results per request, the final one marked last.
// Configuration: i_cfg_we writes i_cfg_wdata into the report entry limit
// (reset 10, values above 32 act as 32); write only while idle.
// With the back end idle, a data request leaves the queue, has its 32-bit
// map word read, then is checked and written back; it holds the back end
// throughout. A report adds a setup step, then a read, a load and a scan
// step per 32-bit word scanned plus one scan step per listed entry, then
// the summary.
// A request that is not rejected and carries a new session id first
// refills the 4096-bit map, one word a cycle, all 128 words. Reset runs
// the same fill; requests queue meanwhile (two-entry queue), then stall.
// A stalled receiver holds the output register; the back end waits with it
// while the front queue keeps accepting until full.
module packet_receipt_bitmap_loss_report_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  prblr_pkg::t_in_item         i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output prblr_pkg::t_out_item        o_out_data,
    input  logic                        i_cfg_we,
    input  logic [prblr_pkg::CNT_W-1:0] i_cfg_wdata
);

    prblr_pkg::t_cmd cmd;
    logic            cmd_valid;
    logic            cmd_pop;

    prblr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    prblr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/prblr_front.sv -----
module prblr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  prblr_pkg::t_in_item i_in_data,
    output prblr_pkg::t_cmd     o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);

    prblr_pkg::t_cmd cmd_n;
    prblr_pkg::t_cmd r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            full;
    logic            push;
    logic            pop;

    always_comb begin
        cmd_n.sid    = i_in_data.session_tag;
        cmd_n.num    = i_in_data.packet_number;
        cmd_n.idx    = i_in_data.packet_number - 14'd1;
        cmd_n.beyond = {1'b0, i_in_data.packet_number}
                       > prblr_pkg::POS_W'(prblr_pkg::MAP_BITS);
        cmd_n.lastf  = i_in_data.last_packet_flag;
        cmd_n.ack    = i_in_data.ack_request;
        cmd_n.qtot   = i_in_data.query_total;
        if (i_in_data.session_tag == '0 ||
            (i_in_data.operation == prblr_pkg::OP_DATA
             && i_in_data.packet_number == '0)) begin
            cmd_n.kind = prblr_pkg::CMD_REJ;
        end else if (i_in_data.operation == prblr_pkg::OP_QUERY) begin
            cmd_n.kind = prblr_pkg::CMD_QRY;
        end else begin
            cmd_n.kind = prblr_pkg::CMD_DATA;
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign push        = i_in_valid && !full;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_in_stall  = full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

// ----- rtl/core/prblr_back.sv -----
module prblr_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prblr_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  prblr_pkg::t_cmd                    i_cmd,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output prblr_pkg::t_out_item               o_out_data
);

    localparam logic [3:0] ST_FILL  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DISP  = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_RINIT = 4'd4;
    localparam logic [3:0] ST_RRD   = 4'd5;
    localparam logic [3:0] ST_RLOAD = 4'd6;
    localparam logic [3:0] ST_RSCAN = 4'd7;
    localparam logic [3:0] ST_RSUM  = 4'd8;

    localparam int NUM_W  = prblr_pkg::NUM_W;
    localparam int POS_W  = prblr_pkg::POS_W;
    localparam int CNT_W  = prblr_pkg::CNT_W;
    localparam int RECV_W = prblr_pkg::RECV_W;
    localparam int WORD_W = prblr_pkg::WORD_W;
    localparam int BIT_W  = prblr_pkg::BIT_W;
    localparam int WADDR_W = prblr_pkg::WADDR_W;

    logic [WORD_W-1:0]  r_mem [prblr_pkg::MAP_WORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [WADDR_W-1:0] mem_raddr;

    logic [3:0]                      r_state, n_state;
    prblr_pkg::t_cmd                 r_cmd, n_cmd;
    logic                            r_cont, n_cont;
    logic [WADDR_W-1:0]              r_fill_addr, n_fill_addr;
    logic [prblr_pkg::SID_W-1:0]     r_sess, n_sess;
    logic [RECV_W-1:0]               r_recv, n_recv;
    logic [NUM_W-1:0]                r_exp, n_exp;
    logic [NUM_W-1:0]                r_hint, n_hint;
    logic [CNT_W-1:0]                r_max;
    logic [CNT_W-1:0]                r_limit, n_limit;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic [POS_W-1:0]                r_end, n_end;
    logic [NUM_W-1:0]                r_first, n_first;
    logic [WORD_W-1:0]               r_work, n_work;
    logic                            r_out_valid;
    prblr_pkg::t_out_item            r_out, n_out;
    logic                            out_load;
    logic                            out_free;

    logic [RECV_W-1:0]  recv_inc;
    logic               hit_bit;
    logic [10:0]        hint_byte;
    logic [NUM_W-1:0]   start_num;
    logic [POS_W-1:0]   word_base;
    logic [POS_W-1:0]   span;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  low_one;
    logic [BIT_W-1:0]   low_idx;
    logic [POS_W-1:0]   entry_num;

    function automatic prblr_pkg::t_out_item mk_out(
        input logic [2:0]        kind,
        input logic [NUM_W-1:0]  miss,
        input logic [CNT_W-1:0]  loss,
        input logic [RECV_W-1:0] recv,
        input logic              lst
    );
        prblr_pkg::t_out_item o;
        o.result_kind    = kind;
        o.missing_packet = miss;
        o.loss_count     = loss;
        o.received_count = recv;
        o.last           = lst;
        return o;
    endfunction

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign recv_inc  = (r_recv == prblr_pkg::RECV_MAX) ? r_recv : r_recv + 13'd1;
    assign hit_bit   = r_rdata[r_cmd.idx[BIT_W-1:0]];
    assign hint_byte = r_hint[NUM_W-1:3];
    assign start_num = (hint_byte != '0) ? {hint_byte - 11'd1, 3'b000} : '0;
    assign word_base = {r_pos[POS_W-1:BIT_W], {BIT_W{1'b0}}};
    assign span      = r_end - word_base;
    assign lo_mask   = {WORD_W{1'b1}} << r_pos[BIT_W-1:0];
    assign hi_mask   = (span >= POS_W'(WORD_W)) ? {WORD_W{1'b1}}
                       : ~({WORD_W{1'b1}} << span[BIT_W-1:0]);
    assign low_one   = r_work & (~r_work + 32'd1);
    assign entry_num = word_base + POS_W'(low_idx) + 15'd1;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low_one[i]) begin
                low_idx = low_idx | BIT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cont      = r_cont;
        n_fill_addr = r_fill_addr;
        n_sess      = r_sess;
        n_recv      = r_recv;
        n_exp       = r_exp;
        n_hint      = r_hint;
        n_limit     = r_limit;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_end       = r_end;
        n_first     = r_first;
        n_work      = r_work;
        n_out       = r_out;
        out_load    = 1'b0;
        o_cmd_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_fill_addr;
        mem_wdata   = {WORD_W{1'b1}};
        mem_re      = 1'b0;
        mem_raddr   = r_cmd.idx[BIT_W+WADDR_W-1:BIT_W];

        case (r_state)
            ST_FILL: begin
                mem_we      = 1'b1;
                n_fill_addr = r_fill_addr + WADDR_W'(1);
                if (r_fill_addr == WADDR_W'(prblr_pkg::MAP_WORDS - 1)) begin
                    n_fill_addr = '0;
                    n_state     = r_cont ? ST_DISP : ST_IDLE;
                    n_cont      = 1'b0;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = ST_DISP;
                end
            end
            ST_DISP: begin
                if (r_cmd.kind == prblr_pkg::CMD_REJ) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_out    = mk_out(prblr_pkg::KIND_REJ, '0, '0, r_recv, 1'b1);
                        n_state  = ST_IDLE;
                    end
                end else if (r_cmd.sid != r_sess) begin
                    n_sess  = r_cmd.sid;
                    n_recv  = '0;
                    n_exp   = '0;
                    n_hint  = '0;
                    n_cont  = 1'b1;
                    n_state = ST_FILL;
                end else if (r_cmd.kind == prblr_pkg::CMD_QRY) begin
                    n_exp   = r_cmd.qtot;
                    n_state = ST_RINIT;
                end else if (r_cmd.beyond) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_out    = mk_out(prblr_pkg::KIND_DUP, '0, '0, r_recv, 1'b1);
                        n_state  = ST_IDLE;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                mem_waddr = r_cmd.idx[BIT_W+WADDR_W-1:BIT_W];
                mem_wdata = r_rdata & ~(32'd1 << r_cmd.idx[BIT_W-1:0]);
                if (!hit_bit) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_out    = mk_out(prblr_pkg::KIND_DUP, '0, '0, r_recv, 1'b1);
                        n_state  = ST_IDLE;
                    end
                end else if (r_cmd.ack) begin
                    mem_we  = 1'b1;
                    n_recv  = recv_inc;
                    n_exp   = r_cmd.lastf ? r_cmd.num : prblr_pkg::ALL_MORE;
                    n_state = ST_RINIT;
                end else if (out_free) begin
                    mem_we   = 1'b1;
                    n_recv   = recv_inc;
                    out_load = 1'b1;
                    n_out    = mk_out(prblr_pkg::KIND_NEW, '0, '0, recv_inc, 1'b1);
                    n_state  = ST_IDLE;
                end
            end
            ST_RINIT: begin
                n_limit = (r_max > prblr_pkg::ENTRY_CAP) ? prblr_pkg::ENTRY_CAP : r_max;
                n_cnt   = '0;
                n_pos   = POS_W'(start_num);
                n_end   = ({1'b0, r_exp} > POS_W'(prblr_pkg::MAP_BITS))
                          ? POS_W'(prblr_pkg::MAP_BITS) : {1'b0, r_exp};
                if (r_recv == RECV_W'(r_exp) && r_exp[NUM_W-1] == 1'b0) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        n_out    = mk_out(prblr_pkg::KIND_SUM, '0, '0, r_recv, 1'b1);
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_state = ST_RRD;
                end
            end
            ST_RRD: begin
                mem_raddr = r_pos[BIT_W+WADDR_W-1:BIT_W];
                if (r_pos >= r_end || r_cnt == r_limit) begin
                    n_state = ST_RSUM;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_RLOAD;
                end
            end
            ST_RLOAD: begin
                n_work  = r_rdata & lo_mask & hi_mask;
                n_state = ST_RSCAN;
            end
            ST_RSCAN: begin
                if (r_work == '0) begin
                    n_pos   = word_base + POS_W'(WORD_W);
                    n_state = ST_RRD;
                end else if (r_cnt == r_limit) begin
                    n_state = ST_RSUM;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_out    = mk_out(prblr_pkg::KIND_MISS, entry_num[NUM_W-1:0], '0,
                                      r_recv, 1'b0);
                    if (r_cnt == '0) begin
                        n_first = entry_num[NUM_W-1:0];
                    end
                    n_cnt  = r_cnt + 6'd1;
                    n_work = r_work & ~low_one;
                end
            end
            ST_RSUM: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out    = mk_out(prblr_pkg::KIND_SUM, '0, r_cnt, r_recv, 1'b1);
                    n_hint   = (r_cnt != '0) ? r_first : r_exp;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_limit <= n_limit;
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_end   <= n_end;
        r_first <= n_first;
        r_work  <= n_work;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_cont      <= 1'b0;
            r_fill_addr <= '0;
            r_sess      <= '0;
            r_recv      <= '0;
            r_exp       <= '0;
            r_hint      <= '0;
            r_max       <= prblr_pkg::MAX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cont      <= n_cont;
            r_fill_addr <= n_fill_addr;
            r_sess      <= n_sess;
            r_recv      <= n_recv;
            r_exp       <= n_exp;
            r_hint      <= n_hint;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/prblr_checker.sv -----
module prblr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input prblr_pkg::t_out_item i_out_data
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_entry_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == prblr_pkg::KIND_MISS |->
        !i_out_data.last && i_out_data.missing_packet != '0
        && i_out_data.loss_count == '0)
        else $error("malformed missing entry");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind != prblr_pkg::KIND_MISS |->
        i_out_data.last && (i_out_data.loss_count <= prblr_pkg::ENTRY_CAP))
        else $error("closing result not marked last");

endmodule

bind packet_receipt_bitmap_loss_report_top prblr_checker u_prblr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ----- verif/packet_receipt_bitmap_loss_report_checker.sv -----
`timescale 1ns / 1ps

module packet_receipt_bitmap_loss_report_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  prblr_pkg::t_in_item         i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  prblr_pkg::t_out_item        i_out_data,
    input  logic                        i_cfg_we,
    input  logic [prblr_pkg::CNT_W-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    logic [prblr_pkg::MAP_BITS-1:0] missing_map;
    logic [prblr_pkg::SID_W-1:0]    sess;
    logic [prblr_pkg::RECV_W-1:0]   recv_total;
    logic [prblr_pkg::NUM_W-1:0]    exp_total;
    logic [prblr_pkg::NUM_W-1:0]    hint;
    logic [prblr_pkg::CNT_W-1:0]    entry_limit;
    prblr_pkg::t_out_item           expected_results[$];
    int                             mismatches = 0;
    int                             compared = 0;

    task automatic push_result(input logic [2:0] kind, input int miss, input int loss,
                               input logic last);
        prblr_pkg::t_out_item r;
        r.result_kind    = kind;
        r.missing_packet = miss[prblr_pkg::NUM_W-1:0];
        r.loss_count     = loss[prblr_pkg::CNT_W-1:0];
        r.received_count = recv_total;
        r.last           = last;
        expected_results.push_back(r);
    endtask

    task automatic build_loss_report();
        int limit;
        int cnt;
        int n;
        int hb;
        int first_num;
        limit = (entry_limit > prblr_pkg::ENTRY_CAP) ? int'(prblr_pkg::ENTRY_CAP)
                                                     : int'(entry_limit);
        cnt = 0;
        first_num = 0;
        if (int'(recv_total) != int'(exp_total)) begin
            hb = int'(hint) >> 3;
            n = (hb > 0) ? (hb - 1) * 8 : 0;
            while (n < int'(exp_total) && n < prblr_pkg::MAP_BITS) begin
                if (missing_map[n]) begin
                    if (cnt == limit) break;
                    if (cnt == 0) first_num = n + 1;
                    push_result(prblr_pkg::KIND_MISS, n + 1, 0, 1'b0);
                    cnt++;
                end
                n++;
            end
            hint = (cnt != 0) ? first_num[prblr_pkg::NUM_W-1:0] : exp_total;
        end
        push_result(prblr_pkg::KIND_SUM, 0, cnt, 1'b1);
    endtask

    task automatic predict_request(input prblr_pkg::t_in_item it);
        int idx;
        if (it.session_tag == '0 ||
            (it.operation == prblr_pkg::OP_DATA && it.packet_number == '0)) begin
            push_result(prblr_pkg::KIND_REJ, 0, 0, 1'b1);
            return;
        end
        if (it.session_tag != sess) begin
            missing_map = '1;
            recv_total  = '0;
            exp_total   = '0;
            hint        = '0;
            sess        = it.session_tag;
        end
        if (it.operation == prblr_pkg::OP_QUERY) begin
            exp_total = it.query_total;
            build_loss_report();
            return;
        end
        idx = int'(it.packet_number) - 1;
        if (idx >= prblr_pkg::MAP_BITS || !missing_map[idx]) begin
            push_result(prblr_pkg::KIND_DUP, 0, 0, 1'b1);
            return;
        end
        missing_map[idx] = 1'b0;
        if (recv_total != prblr_pkg::RECV_MAX) recv_total++;
        if (it.ack_request) begin
            exp_total = it.last_packet_flag ? it.packet_number : prblr_pkg::ALL_MORE;
            build_loss_report();
        end else begin
            push_result(prblr_pkg::KIND_NEW, 0, 0, 1'b1);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input prblr_pkg::t_out_item got);
        prblr_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual kind %0d num %0d",
                     $time, got.result_kind, got.missing_packet);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        compared++;
        compare_field("result_kind", want.result_kind, got.result_kind);
        compare_field("missing_packet", want.missing_packet, got.missing_packet);
        compare_field("loss_count", want.loss_count, got.loss_count);
        compare_field("received_count", want.received_count, got.received_count);
        compare_field("last", want.last, got.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            missing_map = '1;
            sess        = '0;
            recv_total  = '0;
            exp_total   = '0;
            hint        = '0;
            entry_limit = prblr_pkg::MAX_RESET;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_cfg_we) entry_limit = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_request(i_in_data);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
        o_checked    <= compared;
    end

endmodule

// ----- verif/packet_receipt_bitmap_loss_report_top_tb.sv -----
`timescale 1ns / 1ps

module packet_receipt_bitmap_loss_report_top_tb;

    localparam int   PHASES   = 8;
    localparam int   PHASE_REQS = 24;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    prblr_pkg::t_in_item           in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    prblr_pkg::t_out_item          out_data;
    logic                          cfg_we = 1'b0;
    logic [prblr_pkg::CNT_W-1:0]   cfg_wdata = '0;
    int                            fail_count;
    int                            pending;
    int                            checked;

    t_idle_mode                    idle_mode = IDLE_NONE;
    logic [prblr_pkg::SID_W-1:0]   sess_id = 8'd1;
    int                            xfer_len = 16;
    int                            reqs_sent = 0;
    int                            limit_writes = 0;

    packet_receipt_bitmap_loss_report_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    packet_receipt_bitmap_loss_report_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit idle_draw(input bit sender_side);
        case (idle_mode)
            IDLE_SEND: return sender_side && ($urandom_range(0, 99) < 58);
            IDLE_RECV: return !sender_side && ($urandom_range(0, 99) < 58);
            IDLE_BOTH: return $urandom_range(0, 99) < 31;
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge clk) begin
        out_stall <= idle_draw(1'b0);
    end

    function automatic prblr_pkg::t_in_item mk_req(input logic op, input int sid,
                                                   input int num, input logic lastf,
                                                   input logic ack, input int qtot);
        prblr_pkg::t_in_item it;
        it.operation        = op;
        it.session_tag      = sid[prblr_pkg::SID_W-1:0];
        it.packet_number    = num[prblr_pkg::NUM_W-1:0];
        it.last_packet_flag = lastf;
        it.ack_request      = ack;
        it.query_total      = qtot[prblr_pkg::NUM_W-1:0];
        return it;
    endfunction

    task automatic send_req(input prblr_pkg::t_in_item it);
        @(negedge clk);
        while (idle_draw(1'b1)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        reqs_sent++;
    endtask

    // hold off until every expected result is in, then let the block settle
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [prblr_pkg::CNT_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_writes++;
    endtask

    task automatic gen_request(output prblr_pkg::t_in_item it);
        logic [63:0] raw;
        int          pick;
        int          num;
        raw  = {$urandom, $urandom};
        it   = raw[$bits(prblr_pkg::t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) return;
        if (pick < 12) begin
            sess_id  = prblr_pkg::SID_W'($urandom_range(1, 255));
            xfer_len = ($urandom_range(0, 11) == 0) ? $urandom_range(4080, 4200)
                                                     : $urandom_range(4, 60);
        end
        it.session_tag = sess_id;
        if (pick >= 12 && pick < 15) begin
            it.operation = prblr_pkg::OP_DATA;
            if (raw[63]) it.session_tag = '0;
            else         it.packet_number = '0;
        end else if (pick >= 15 && pick < 27) begin
            it.operation   = prblr_pkg::OP_QUERY;
            it.query_total = ($urandom_range(0, 4) == 0) ? raw[63:50]
                                                         : xfer_len[prblr_pkg::NUM_W-1:0];
        end else begin
            it.operation = prblr_pkg::OP_DATA;
            num = ($urandom_range(0, 9) == 0) ? $urandom_range(4090, 4100)
                                              : $urandom_range(1, xfer_len);
            it.ack_request = ($urandom_range(0, 99) < 18);
            if (it.ack_request && it.last_packet_flag && raw[62]) num = xfer_len;
            it.packet_number = num[prblr_pkg::NUM_W-1:0];
        end
    endtask

    initial begin
        logic [prblr_pkg::CNT_W-1:0] limit_table[PHASES];
        t_idle_mode                  mode_table[4];
        prblr_pkg::t_in_item         it;

        limit_table = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd10, 6'd33, 6'd5, 6'd20};
        limit_table[7] = prblr_pkg::CNT_W'($urandom_range(1, 32));
        mode_table  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_req(mk_req(prblr_pkg::OP_DATA, 0, 7, 1'b0, 1'b0, 0));
        send_req(mk_req(prblr_pkg::OP_QUERY, 0, 0, 1'b0, 1'b0, 16383));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 0, 1'b1, 1'b1, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 1, 1'b0, 1'b0, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 1, 1'b0, 1'b1, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 4096, 1'b0, 1'b0, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 4097, 1'b0, 1'b0, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 16383, 1'b1, 1'b1, 16383));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 3, 1'b1, 1'b1, 0));
        send_req(mk_req(prblr_pkg::OP_DATA, 5, 5, 1'b0, 1'b1, 0));
        send_req(mk_req(prblr_pkg::OP_QUERY, 5, 0, 1'b0, 1'b0, 0));
        send_req(mk_req(prblr_pkg::OP_QUERY, 5, 16383, 1'b1, 1'b1, 16383));
        send_req(mk_req(prblr_pkg::OP_QUERY, 255, 0, 1'b0, 1'b0, 40));
        send_req(mk_req(prblr_pkg::OP_QUERY, 255, 0, 1'b0, 1'b0, 40));
        send_req(mk_req(prblr_pkg::OP_DATA, 255, 40, 1'b1, 1'b1, 16383));
        send_req(mk_req(prblr_pkg::OP_DATA, 255, 2, 1'b0, 1'b1, 0));
        send_req(mk_req(prblr_pkg::OP_QUERY, 1, 0, 1'b0, 1'b0, 12));

        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            write_limit(limit_table[p]);
            idle_mode = mode_table[p % 4];
            for (int k = 0; k < PHASE_REQS; k++) begin
                gen_request(it);
                send_req(it);
                if (p == 1 && k == PHASE_REQS / 2) wait_drain();
            end
        end

        wait_drain();
        repeat (20) @(negedge clk);

        $display("Sent %0d requests under %0d entry-limit settings and four idle patterns;",
                 reqs_sent, limit_writes);
        $display("compared %0d results against the bitmap predictor.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
